### rtl/rrtt_pkg.sv
// Shared types and constants of the round-robin thread table.
package rrtt_pkg;

    localparam int ACT_W    = 3;
    localparam int TID_W    = 6;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 7;

    localparam logic [VAL_W-1:0] CANCEL_VALUE = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE  = 3'd0,
        ACT_FINISH  = 3'd1,
        ACT_CANCEL  = 3'd2,
        ACT_ADVANCE = 3'd3,
        ACT_JOIN    = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_PENDING   = 3'd1,
        ST_NO_THREAD = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_WALK,
        S_ADV,
        S_JOIN,
        S_OUT
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [TID_W-1:0]  thread;
        logic [VAL_W-1:0]  ret;
        logic [LIVE_W-1:0] live;
    } result_t;

endpackage

### rtl/rrtt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module rrtt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rrtt_ctrl.sv
// Sequencer of the thread table: pointers, counters and read-modify-write of both RAMs.
module rrtt_ctrl #(
    parameter int MAX_THREADS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rrtt_pkg::ACT_W-1:0]   action,
    input  logic [rrtt_pkg::TID_W-1:0]   thread_id,
    input  logic [rrtt_pkg::VAL_W-1:0]   value,
    output logic                         res_valid,
    input  logic                         res_ready,
    output rrtt_pkg::result_t            res
);

    import rrtt_pkg::*;

    localparam int IDW = $clog2(MAX_THREADS);
    localparam int CW  = $clog2(MAX_THREADS + 1);
    localparam int VW  = VAL_W + 1;   // ready mark on top of the value

    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [TID_W-1:0]  tid_reg, tid_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [IDW-1:0]    head_reg, head_next;
    logic [IDW-1:0]    tail_reg, tail_next;
    logic [IDW-1:0]    cur_reg, cur_next;
    logic [IDW-1:0]    up_reg, up_next;
    logic [IDW-1:0]    prev_reg, prev_next;
    logic [IDW-1:0]    succ_reg, succ_next;
    logic [IDW-1:0]    newid_reg, newid_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idcnt_reg, idcnt_next;
    status_t           status_reg, status_next;
    logic [VAL_W-1:0]  ret_reg, ret_next;
    logic              created_reg, created_next;

    // RAM ports
    logic              lk_we, lk_re;
    logic [IDW-1:0]    lk_waddr, lk_raddr, lk_wdata, lk_rdata;
    logic              vr_we, vr_re;
    logic [IDW-1:0]    vr_waddr, vr_raddr;
    logic [VW-1:0]     vr_wdata, vr_rdata;

    // decisions
    logic              tid_created;
    logic [IDW-1:0]    tid_idx;
    logic              table_full;
    logic              count_zero;
    logic              rd_ready;
    logic              walk_found;
    logic              walk_end;

    rrtt_ram #(.DEPTH(MAX_THREADS), .WIDTH(IDW)) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    rrtt_ram #(.DEPTH(MAX_THREADS), .WIDTH(VW)) u_value_ram (
        .clk   (clk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata (vr_wdata),
        .re    (vr_re),
        .raddr (vr_raddr),
        .rdata (vr_rdata)
    );

    always_comb
    begin
        // ids are handed out in order, so "created" is simply id below the counter
        tid_created = (32'(tid_reg) < MAX_THREADS) && (32'(tid_reg) < 32'(idcnt_reg));
        tid_idx     = IDW'(tid_reg);
        table_full  = 32'(idcnt_reg) >= MAX_THREADS;
        count_zero  = count_reg == '0;
        rd_ready    = vr_rdata[VAL_W];
        walk_end    = prev_reg == tail_reg;
        walk_found  = lk_rdata == tid_idx;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (act_reg)
                    ACT_FINISH, ACT_CANCEL:
                        state_next = tid_created ? S_CHECK : S_OUT;
                    ACT_ADVANCE:
                        state_next = (!count_zero && up_reg != tail_reg) ? S_ADV : S_OUT;
                    ACT_JOIN:
                        state_next = tid_created ? S_JOIN : S_OUT;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_CHECK:
            begin
                state_next = (rd_ready || tid_idx == head_reg) ? S_OUT : S_WALK;
            end
            S_WALK:
            begin
                if (walk_end || walk_found)
                begin
                    state_next = S_OUT;
                end
            end
            S_ADV, S_JOIN:
                state_next = S_OUT;
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath, RAM requests and handshake outputs
    always_comb
    begin
        act_next     = act_reg;
        tid_next     = tid_reg;
        val_next     = val_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        up_next      = up_reg;
        prev_next    = prev_reg;
        succ_next    = succ_reg;
        newid_next   = newid_reg;
        count_next   = count_reg;
        idcnt_next   = idcnt_reg;
        status_next  = status_reg;
        ret_next     = ret_reg;
        created_next = created_reg;

        lk_we    = 1'b0;
        lk_waddr = tail_reg;
        lk_wdata = '0;
        lk_re    = 1'b0;
        lk_raddr = tid_idx;
        vr_we    = 1'b0;
        vr_waddr = tid_idx;
        vr_wdata = '0;
        vr_re    = 1'b0;
        vr_raddr = tid_idx;

        in_stall   = state_reg != S_IDLE;
        res_valid  = state_reg == S_OUT;
        res.status = status_reg;
        res.thread = created_reg ? TID_W'(newid_reg) : TID_W'(cur_reg);
        res.ret    = ret_reg;
        res.live   = LIVE_W'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = action_t'(action);
                    tid_next     = thread_id;
                    val_next     = value;
                    status_next  = ST_OK;
                    ret_next     = '0;
                    created_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                case (act_reg)
                    ACT_CREATE:
                    begin
                        if (table_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            newid_next   = IDW'(idcnt_reg);
                            created_next = 1'b1;
                            idcnt_next   = idcnt_reg + CW'(1);
                            count_next   = count_reg + CW'(1);
                            // clear the ready mark of the fresh entry
                            vr_we        = 1'b1;
                            vr_waddr     = IDW'(idcnt_reg);
                            vr_wdata     = '0;
                            if (count_zero)
                            begin
                                head_next = IDW'(idcnt_reg);
                                tail_next = IDW'(idcnt_reg);
                                cur_next  = IDW'(idcnt_reg);
                                up_next   = IDW'(idcnt_reg);
                            end
                            else
                            begin
                                lk_we     = 1'b1;
                                lk_waddr  = tail_reg;
                                lk_wdata  = IDW'(idcnt_reg);
                                tail_next = IDW'(idcnt_reg);
                            end
                        end
                    end
                    ACT_FINISH, ACT_CANCEL:
                    begin
                        if (!tid_created)
                        begin
                            status_next = ST_NO_THREAD;
                        end
                        else
                        begin
                            vr_re    = 1'b1;
                            vr_raddr = tid_idx;
                            lk_re    = 1'b1;
                            lk_raddr = tid_idx;
                        end
                    end
                    ACT_ADVANCE:
                    begin
                        if (count_zero)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (up_reg == tail_reg)
                        begin
                            cur_next = up_reg;
                            up_next  = head_reg;
                        end
                        else
                        begin
                            lk_re    = 1'b1;
                            lk_raddr = up_reg;
                        end
                    end
                    ACT_JOIN:
                    begin
                        if (!tid_created)
                        begin
                            status_next = ST_NO_THREAD;
                        end
                        else
                        begin
                            vr_re    = 1'b1;
                            vr_raddr = tid_idx;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (rd_ready)
                begin
                    // already finished: no longer in the order
                    status_next = ST_NO_THREAD;
                end
                else
                begin
                    vr_we    = 1'b1;
                    vr_waddr = tid_idx;
                    vr_wdata = {1'b1, (act_reg == ACT_FINISH) ? val_reg : CANCEL_VALUE};
                    if (tid_idx == head_reg)
                    begin
                        if (count_reg <= CW'(1))
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            cur_next   = '0;
                            up_next    = '0;
                            count_next = '0;
                        end
                        else
                        begin
                            head_next  = lk_rdata;
                            cur_next   = lk_rdata;
                            up_next    = lk_rdata;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        // hunt for the predecessor from the head
                        succ_next = lk_rdata;
                        prev_next = head_reg;
                        lk_re     = 1'b1;
                        lk_raddr  = head_reg;
                    end
                end
            end
            S_WALK:
            begin
                if (!walk_end)
                begin
                    if (walk_found)
                    begin
                        if (up_reg == tid_idx)
                        begin
                            up_next = (tid_idx == tail_reg) ? head_reg : succ_reg;
                        end
                        if (cur_reg == tid_idx)
                        begin
                            cur_next = prev_reg;
                        end
                        if (tid_idx == tail_reg)
                        begin
                            tail_next = prev_reg;
                        end
                        else
                        begin
                            lk_we    = 1'b1;
                            lk_waddr = prev_reg;
                            lk_wdata = succ_reg;
                        end
                        if (!count_zero)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        prev_next = lk_rdata;
                        lk_re     = 1'b1;
                        lk_raddr  = lk_rdata;
                    end
                end
            end
            S_ADV:
            begin
                cur_next = up_reg;
                up_next  = lk_rdata;
            end
            S_JOIN:
            begin
                if (rd_ready)
                begin
                    ret_next = vr_rdata[VAL_W-1:0];
                end
                else
                begin
                    status_next = ST_PENDING;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cur_reg     <= '0;
            up_reg      <= '0;
            count_reg   <= '0;
            idcnt_reg   <= '0;
            created_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cur_reg     <= cur_next;
            up_reg      <= up_next;
            count_reg   <= count_next;
            idcnt_reg   <= idcnt_next;
            created_reg <= created_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        tid_reg    <= tid_next;
        val_reg    <= val_next;
        prev_reg   <= prev_next;
        succ_reg   <= succ_next;
        newid_reg  <= newid_next;
        status_reg <= status_next;
        ret_reg    <= ret_next;
    end

endmodule

### rtl/round_robin_thread_table.sv
// Top level of the round-robin thread table: sequencer plus output register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  request  | in_valid/in_stall  | action, thread_id, value
//  result   | out_valid/out_stall| status, out_thread, ret_value, live_count
//
// One request is in work at a time; in_stall is high from acceptance until its
// result has moved into the output register. Create, advance across the wrap and
// any request refused at decode go from decode straight to the result. Advance
// and join query add one link or value RAM read, as do finish and cancel of the
// head or of a thread already out of the order; any other finish or cancel adds
// a predecessor walk through the link RAM as well, one link a cycle, over up to
// MAX_THREADS - 1 links. A stalled output register holds the result in the
// sequencer until the register is free.
// Reset clears all pointers, counters and handshake state; RAM contents need no
// clearing since an id is live only below the id counter.
// A stalled result holds in the output register while the next request is taken.
module round_robin_thread_table #(
    parameter int MAX_THREADS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rrtt_pkg::ACT_W-1:0]    action,
    input  logic [rrtt_pkg::TID_W-1:0]    thread_id,
    input  logic [rrtt_pkg::VAL_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rrtt_pkg::STATUS_W-1:0] status,
    output logic [rrtt_pkg::TID_W-1:0]    out_thread,
    output logic [rrtt_pkg::VAL_W-1:0]    ret_value,
    output logic [rrtt_pkg::LIVE_W-1:0]   live_count
);

    import rrtt_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg;
    result_t out_res_reg;

    rrtt_ctrl #(.MAX_THREADS(MAX_THREADS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .thread_id (thread_id),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register frees up when empty or being taken this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign out_thread = out_res_reg.thread;
    assign ret_value  = out_res_reg.ret;
    assign live_count = out_res_reg.live;

endmodule
